// ----- hdl/lobm_pkg.sv -----
// Shared types and constants for the last-occurrence byte matcher.
// No dependencies; every other file of the block imports this package.
package lobm_pkg;

    // Size limits
    localparam int QUERY_MAX   = 16;
    localparam int REF_MAX     = 65535;
    localparam int QUEUE_DEPTH = 4;

    // Derived widths
    localparam int SYM_W   = 8;
    localparam int POS_W   = 16;
    localparam int QCNT_W  = $clog2(QUERY_MAX + 1);
    localparam int RCNT_W  = $clog2(REF_MAX + 1);
    localparam int CMP_W   = (RCNT_W > QCNT_W) ? RCNT_W : QCNT_W;
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W = $clog2(QUEUE_DEPTH + 1);

    // func codes
    localparam logic FUNC_QUERY = 1'b0;
    localparam logic FUNC_REF   = 1'b1;

    // Input word
    typedef struct packed {
        logic             func;
        logic [SYM_W-1:0] symbol;
        logic             last;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             overflow;
    } out_word_t;

    // Classified word held between front and back
    typedef struct packed {
        logic             is_ref;
        logic             first;
        logic             last;
        logic [SYM_W-1:0] symbol;
    } queue_entry_t;

endpackage

// ----- hdl/lobm_front.sv -----
// Front end: accepts input words, tracks query framing, drops stray reference bytes.
// Depends on lobm_pkg.
module lobm_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lobm_pkg::in_word_t    s_data,
    input  logic                  q_full,
    output logic                  q_push,
    output lobm_pkg::queue_entry_t q_data
);
    import lobm_pkg::*;

    logic open_reg;
    logic open_next;
    logic accept;
    logic is_query;
    logic drop;

    // Classify the incoming word
    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign is_query = (s_data.func == FUNC_QUERY);
    // reference bytes during an open query are ignored
    assign drop     = !is_query && open_reg;
    assign q_push   = accept && !drop;

    always_comb begin
        q_data.is_ref = !is_query;
        q_data.first  = is_query && !open_reg;
        q_data.last   = s_data.last;
        q_data.symbol = s_data.symbol;
    end

    // Query open flag
    always_comb begin
        open_next = open_reg;
        if (accept && is_query) begin
            open_next = !s_data.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= 1'b0;
        end else begin
            open_reg <= open_next;
        end
    end

endmodule

// ----- hdl/lobm_queue.sv -----
// Short FIFO between the front and back ends.
// Depends on lobm_pkg.
module lobm_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  lobm_pkg::queue_entry_t push_data,
    output logic                   full,
    input  logic                   pop,
    output lobm_pkg::queue_entry_t pop_data,
    output logic                   empty
);
    import lobm_pkg::*;

    queue_entry_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg;
    logic [QPTR_W-1:0]    rd_ptr_reg;
    logic [QFILL_W-1:0]   fill_reg;
    logic [QFILL_W-1:0]   fill_next;
    logic                 do_push;
    logic                 do_pop;

    assign full     = (fill_reg == QFILL_W'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    // Fill level
    always_comb begin
        fill_next = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            fill_reg <= fill_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTH
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= QFILL_W'(QUEUE_DEPTH))
        else $error("queue fill level above depth");
    a_fill_track: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push && !do_pop |=> fill_reg != '0)
        else $error("queue empty right after a push");
    a_ptr_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers differ while empty");
`endif

endmodule

// ----- hdl/lobm_back.sv -----
// Back end: query store, reference window, parallel compare and result register.
// Depends on lobm_pkg.
module lobm_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_empty,
    input  lobm_pkg::queue_entry_t q_data,
    output logic                   q_pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output lobm_pkg::out_word_t    m_data
);
    import lobm_pkg::*;

    // Query bytes, newest at index 0, so entry j lines up with window entry j
    logic [SYM_W-1:0]  qstore_reg [QUERY_MAX];
    logic [SYM_W-1:0]  window_reg [QUERY_MAX];
    logic [SYM_W-1:0]  win_shift  [QUERY_MAX];

    logic [QCNT_W-1:0] qc_reg, qc_next, qc_base;
    logic              ovf_reg, ovf_next, ovf_base;
    logic [RCNT_W-1:0] rc_reg, rc_next, rc_inc;
    logic [RCNT_W-1:0] mstart_reg, mstart_next;
    logic              seen_reg, seen_next;
    logic              m_valid_reg;
    out_word_t         m_data_reg, result_next;

    logic              q_write;
    logic              win_write;
    logic              emit_word;
    logic              emit;
    logic              lanes_ok;
    logic              hit;
    logic [QUERY_MAX-1:0] lane_ok;

    // Execute one word a cycle; only a word that ends a reference waits
    // for the result register to free up
    assign emit_word = q_data.is_ref && q_data.last;
    assign q_pop     = !q_empty && (!emit_word || !m_valid_reg || m_ready);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign emit      = q_pop && emit_word;

    // Query side
    assign qc_base   = q_data.first ? '0 : qc_reg;
    assign ovf_base  = q_data.first ? 1'b0 : ovf_reg;
    assign q_write   = q_pop && !q_data.is_ref && (qc_base < QCNT_W'(QUERY_MAX));

    // Reference side: shift, then compare every active lane
    assign win_write = q_pop && q_data.is_ref && (rc_reg != RCNT_W'(REF_MAX));
    assign rc_inc    = rc_reg + 1'b1;

    always_comb begin
        win_shift[0] = q_data.symbol;
        for (int j = 1; j < QUERY_MAX; j++) begin
            win_shift[j] = window_reg[j-1];
        end
        for (int j = 0; j < QUERY_MAX; j++) begin
            lane_ok[j] = (QCNT_W'(j) >= qc_reg) || (win_shift[j] == qstore_reg[j]);
        end
    end

    assign lanes_ok = &lane_ok;
    assign hit = (qc_reg != '0) && (CMP_W'(rc_inc) >= CMP_W'(qc_reg)) && lanes_ok;

    // Next state
    always_comb begin
        qc_next     = qc_reg;
        ovf_next    = ovf_reg;
        rc_next     = rc_reg;
        mstart_next = mstart_reg;
        seen_next   = seen_reg;
        if (q_pop && !q_data.is_ref) begin
            qc_next  = q_write ? qc_base + 1'b1 : qc_base;
            ovf_next = q_write ? ovf_base : 1'b1;
        end else if (q_pop && q_data.is_ref) begin
            if (win_write) begin
                rc_next = rc_inc;
                if (hit) begin
                    mstart_next = RCNT_W'(CMP_W'(rc_inc) - CMP_W'(qc_reg));
                    seen_next   = 1'b1;
                end
            end else begin
                ovf_next = 1'b1;
            end
        end

        // Result from the state after this word
        if (qc_reg == '0) begin
            result_next.found    = 1'b1;
            result_next.position = POS_W'(rc_next);
        end else begin
            result_next.found    = seen_next;
            result_next.position = seen_next ? POS_W'(mstart_next) : '0;
        end
        result_next.overflow = ovf_next;

        // Closing a query or ending a reference restarts the reference
        if (q_pop && q_data.last) begin
            rc_next     = '0;
            mstart_next = '0;
            seen_next   = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qc_reg      <= '0;
            ovf_reg     <= 1'b0;
            rc_reg      <= '0;
            mstart_reg  <= '0;
            seen_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            qc_reg     <= qc_next;
            ovf_reg    <= ovf_next;
            rc_reg     <= rc_next;
            mstart_reg <= mstart_next;
            seen_reg   <= seen_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: lanes beyond the count or the stream length are never compared
    always_ff @(posedge aclk) begin
        if (q_write) begin
            qstore_reg[0] <= q_data.symbol;
            for (int j = 1; j < QUERY_MAX; j++) begin
                qstore_reg[j] <= qstore_reg[j-1];
            end
        end
        if (win_write) begin
            for (int j = 0; j < QUERY_MAX; j++) begin
                window_reg[j] <= win_shift[j];
            end
        end
        if (emit) begin
            m_data_reg <= result_next;
        end
    end

`ifndef SYNTH
    a_qc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        qc_reg <= QCNT_W'(QUERY_MAX))
        else $error("query count above limit");
    a_rc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rc_reg <= RCNT_W'(REF_MAX))
        else $error("reference count above limit");
    a_seen_needs_query: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg |-> qc_reg != '0)
        else $error("match recorded with empty query");
    a_miss_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg.found |-> m_data_reg.position == '0)
        else $error("miss reported with nonzero position");
    a_emit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_valid_reg)
        else $error("result not presented after end of reference");
`endif

endmodule

// ----- hdl/last_occurrence_byte_matcher_unit.sv -----
// Top level of the last-occurrence byte matcher: front, queue and back end.
// Depends on lobm_pkg, lobm_front, lobm_queue and lobm_back.
//
//   channel  ports                        word
//   input    s_valid s_ready s_data       func, symbol, last
//   result   m_valid m_ready m_data       found, position, overflow
//
// Sustained rate is one word per cycle unless a result waits on m_ready; the back
// end executes one queued word a cycle (window shift plus parallel compare of all
// query lanes). A word ending a reference passes a queue entry, then the result register.
// The four-entry queue lets the input keep flowing while a result waits.
// Reset is synchronous, active low, and clears all control state.
module last_occurrence_byte_matcher_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lobm_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lobm_pkg::out_word_t m_data
);
    import lobm_pkg::*;

    logic         q_push;
    logic         q_full;
    logic         q_pop;
    logic         q_empty;
    queue_entry_t q_in;
    queue_entry_t q_out;

    lobm_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    lobm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    lobm_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
